// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: expr");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`endif

// File: src/ptlu_pkg.sv
`timescale 1ns / 1ps

package ptlu_pkg;

    localparam int KEY_W   = 32;
    localparam int ADDR_W  = 48;
    localparam int TIME_W  = 63;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic [1:0] OP_UPSERT  = 2'd0;
    localparam logic [1:0] OP_RESOLVE = 2'd1;
    localparam logic [1:0] OP_PURGE   = 2'd2;

    // max_age is register 0; 64-bit registers sit on 8-byte boundaries
    localparam logic REG_MAX_AGE = 1'b0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [KEY_W-1:0]  node_key;
        logic [ADDR_W-1:0] address_in;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  address_out;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] purged_count;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] seen_time;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } store_ctrl_t;

endpackage

// File: src/peer_table_lru_upsert.sv
`timescale 1ns / 1ps
// One item in flight: a new item is accepted only in idle, after the previous result
// has been taken.
// Each item scans every slot through one table read port and one shared
// subtract/compare unit, one slot per cycle.
// Reset (aresetn low, synchronous) invalidates all slots and clears max_age.
module peer_table_lru_upsert
    import ptlu_pkg::*;
#(
    parameter int PEER_SLOTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int IDX_W = $clog2(PEER_SLOTS);
    localparam int CNT_W = $clog2(PEER_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PEER_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOT_CNT  = CNT_W'(PEER_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    function automatic logic [SLOT_W-1:0] slot_bits(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    in_item_t            item_reg;
    logic [TIME_W-1:0]   max_age_reg;
    out_item_t           out_reg, out_next;

    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [ADDR_W-1:0]   hit_addr_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                best_have_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [TIME_W-1:0]   best_time_reg;
    logic [COUNT_W-1:0]  purged_reg;

    store_ctrl_t         st_ctrl;
    entry_t              rd_entry;
    entry_t              wr_entry;
    logic                cmp_valid;
    logic [IDX_W-1:0]    wr_idx;

    logic                is_purge;
    logic [TIME_W-1:0]   sub_a, sub_b;
    logic [TIME_W:0]     diff;
    logic                key_hit;
    logic                older;
    logic                stale;
    logic                cfg_wr;

    ptlu_store #(
        .SLOTS (PEER_SLOTS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (st_ctrl),
        .rd_idx    (rd_cnt_reg[IDX_W-1:0]),
        .rd_data   (rd_entry),
        .chk_idx   (cmp_idx_reg),
        .chk_valid (cmp_valid),
        .wr_idx    (wr_idx),
        .wr_data   (wr_entry)
    );

    // shared subtractor: age for purge, time order for victim search
    assign is_purge = (item_reg.opcode == OP_PURGE);
    assign sub_a    = is_purge ? item_reg.now_time : rd_entry.seen_time;
    assign sub_b    = is_purge ? rd_entry.seen_time : best_time_reg;
    assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
    assign older    = diff[TIME_W];
    assign stale    = cmp_valid && !diff[TIME_W] && (diff[TIME_W-1:0] > max_age_reg);
    assign key_hit  = cmp_valid && (rd_entry.key == item_reg.node_key);

    assign wr_idx   = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : best_idx_reg);
    assign wr_entry = '{key:       item_reg.node_key,
                        address:   item_reg.address_in,
                        seen_time: item_reg.now_time};

    assign st_ctrl.rd_en  = (state_reg == ST_SCAN) && (rd_cnt_reg < SLOT_CNT);
    assign st_ctrl.wr_en  = (state_reg == ST_DONE) && (item_reg.opcode == OP_UPSERT);
    assign st_ctrl.clr_en = (state_reg == ST_SCAN) && cmp_vld_reg && is_purge && stale;

    always_comb begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next  = ST_SCAN;
                    rd_cnt_next = '0;
                end
            end
            ST_SCAN: begin
                if (rd_cnt_reg < SLOT_CNT) begin
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg && cmp_idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            cmp_idx_reg <= cmp_idx_next;
        end
    end

    // scan accumulators
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg      <= s_data;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            best_have_reg <= 1'b0;
            purged_reg    <= '0;
        end else if (state_reg == ST_SCAN && cmp_vld_reg) begin
            if (key_hit && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= cmp_idx_reg;
                hit_addr_reg <= rd_entry.address;
            end
            if (!cmp_valid && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= cmp_idx_reg;
            end
            if (cmp_valid && !is_purge && (!best_have_reg || older)) begin
                best_have_reg <= 1'b1;
                best_idx_reg  <= cmp_idx_reg;
                best_time_reg <= rd_entry.seen_time;
            end
            if (is_purge && stale && purged_reg != COUNT_MAX) begin
                purged_reg <= purged_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_next = '0;
        case (item_reg.opcode)
            OP_UPSERT: begin
                out_next.found = hit_reg;
                out_next.slot  = slot_bits(wr_idx);
            end
            OP_RESOLVE: begin
                if (hit_reg) begin
                    out_next.found       = 1'b1;
                    out_next.address_out = hit_addr_reg;
                    out_next.slot        = slot_bits(hit_idx_reg);
                end
            end
            OP_PURGE: begin
                out_next.purged_count = purged_reg;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE) begin
            out_reg <= out_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_RESP);
    assign m_data  = out_reg;

    // register file: 64-bit registers decoded on paddr[3]
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_MAX_AGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg <= '0;
        end else if (cfg_wr) begin
            max_age_reg <= pwdata[TIME_W-1:0];
        end
    end

    assign prdata = (paddr[3] == REG_MAX_AGE) ? {1'b0, max_age_reg} : '0;
    assign pready = 1'b1;

endmodule

// File: src/ptlu_store.sv
`timescale 1ns / 1ps

module ptlu_store
    import ptlu_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  store_ctrl_t               ctrl,
    input  logic [$clog2(SLOTS)-1:0]  rd_idx,
    output entry_t                    rd_data,
    input  logic [$clog2(SLOTS)-1:0]  chk_idx,
    output logic                      chk_valid,
    input  logic [$clog2(SLOTS)-1:0]  wr_idx,
    input  entry_t                    wr_data
);

    entry_t            mem [SLOTS];
    entry_t            rd_data_reg;
    logic [SLOTS-1:0]  valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // valid bits: reset clears the whole table at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ctrl.wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (ctrl.clr_en) begin
                valid_reg[chk_idx] <= 1'b0;
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign chk_valid = valid_reg[chk_idx];

endmodule

// File: src/ptlu_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptlu_checker
    import ptlu_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result holds
    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one item in flight: never ready while a result waits
    `ASSERT_ALWAYS(a_one_in_flight, aclk, aresetn, !(s_ready && m_valid))

    // a transfer in starts a scan, so no result follows in the next cycle
    `ASSERT_NEXT(a_scan_latency, aclk, aresetn, s_valid && s_ready, !m_valid && !s_ready)

    // purge results carry no lookup status
    `ASSERT_SAME(a_purge_clean, aclk, aresetn, m_valid && m_data.purged_count != 0, !m_data.found && m_data.slot == 0 && m_data.address_out == 0)

    // address only on a hit
    `ASSERT_SAME(a_miss_no_addr, aclk, aresetn, m_valid && !m_data.found, m_data.address_out == 0)

endmodule

bind peer_table_lru_upsert ptlu_checker u_ptlu_checker (.*);

// File: test/peer_table_lru_upsert_tb.sv
`timescale 1ns / 1ps

module peer_table_lru_upsert_tb;
    import ptlu_pkg::*;

    localparam int PEER_SLOTS = 16;
    localparam int KEY_POOL   = 24;
    localparam int SETTLE     = 25;
    localparam int LONG_HOLD  = 300;
    localparam int WATCHDOG   = 2000;
    localparam int MAX_REPORT = 10;

    localparam logic [1:0]        OP_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam logic [KEY_W-1:0]  KEY_MAX   = '1;
    localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // mirror of the peer table
    logic              peer_live [PEER_SLOTS];
    logic [KEY_W-1:0]  peer_key  [PEER_SLOTS];
    logic [ADDR_W-1:0] peer_addr [PEER_SLOTS];
    logic [TIME_W-1:0] peer_seen [PEER_SLOTS];
    logic [TIME_W-1:0] age_limit;

    out_item_t         pending_results [$];
    logic [KEY_W-1:0]  key_pool [KEY_POOL];
    logic [TIME_W-1:0] cur_time;
    int                mismatches;
    int                quiet_cycles;
    bit                row_typed;
    out_item_t         row_want;
    bit                hold_req;
    bit                no_gaps;

    peer_table_lru_upsert #(
        .PEER_SLOTS(PEER_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the mirrored table and return the status it yields.
    function automatic out_item_t apply_request(in_item_t it);
        out_item_t r;
        int hit;
        int pick;
        r = '0;
        hit = -1;
        pick = -1;
        for (int i = 0; i < PEER_SLOTS; i++) begin
            if (hit < 0 && peer_live[i] && peer_key[i] == it.node_key) hit = i;
        end
        case (it.opcode)
            OP_UPSERT: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    pick = hit;
                end else begin
                    for (int i = 0; i < PEER_SLOTS; i++) begin
                        if (pick < 0 && !peer_live[i]) pick = i;
                    end
                    // full table: evict the strictly oldest, lowest index on ties
                    if (pick < 0) begin
                        pick = 0;
                        for (int i = 1; i < PEER_SLOTS; i++) begin
                            if (peer_seen[i] < peer_seen[pick]) pick = i;
                        end
                    end
                end
                peer_live[pick] = 1'b1;
                peer_key[pick]  = it.node_key;
                peer_addr[pick] = it.address_in;
                peer_seen[pick] = it.now_time;
                r.slot = SLOT_W'(pick);
            end
            OP_RESOLVE: begin
                if (hit >= 0) begin
                    r.found       = 1'b1;
                    r.address_out = peer_addr[hit];
                    r.slot        = SLOT_W'(hit);
                end
            end
            OP_PURGE: begin
                for (int i = 0; i < PEER_SLOTS; i++) begin
                    // an entry seen after now has no positive age
                    if (peer_live[i] && it.now_time >= peer_seen[i]
                            && it.now_time - peer_seen[i] > age_limit) begin
                        peer_live[i] = 1'b0;
                        if (r.purged_count != COUNT_MAX) r.purged_count = r.purged_count + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_item_t mk_item(logic [1:0] op, logic [KEY_W-1:0] k,
                                         logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t);
        in_item_t it;
        it.opcode     = op;
        it.node_key   = k;
        it.address_in = a;
        it.now_time   = t;
        return it;
    endfunction

    function automatic out_item_t mk_result(logic f, logic [ADDR_W-1:0] a,
                                            logic [SLOT_W-1:0] s, logic [COUNT_W-1:0] c);
        out_item_t r;
        r.found        = f;
        r.address_out  = a;
        r.slot         = s;
        r.purged_count = c;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_mismatch(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= MAX_REPORT) begin
            $display("%0t %s: exp found=%0b addr=%h slot=%0d purged=%0d", $realtime, what,
                     want.found, want.address_out, want.slot, want.purged_count);
            $display("%0t %s: got found=%0b addr=%h slot=%0d purged=%0d", $realtime, what,
                     got.found, got.address_out, got.slot, got.purged_count);
        end
    endtask

    // Predict on every input transfer, check every result transfer.
    always @(posedge aclk) begin : table_monitor
        out_item_t predicted;
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = apply_request(s_data);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_data);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.found !== want.found || m_data.address_out !== want.address_out
                            || m_data.slot !== want.slot
                            || m_data.purged_count !== want.purged_count)
                        note_mismatch("result mismatch", want, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial begin : result_sink
        int left;
        logic lvl;
        left = 0;
        lvl = 1'b1;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                left = 0;
            end else begin
                if (left == 0) begin
                    if (no_gaps || !lvl) begin
                        lvl = 1'b1;
                        left = no_gaps ? 1 : $urandom_range(1, 12);
                    end else begin
                        lvl = 1'b0;
                        left = gap_len();
                    end
                end
                m_ready <= lvl;
                left--;
            end
        end
    end

    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        s_data    <= it;
        s_valid   <= 1'b1;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drop valid and wait until every request has been answered.
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_max_age(logic [TIME_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * int'(REG_MAX_AGE));
        pwdata  <= PDATA_W'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        age_limit = v;
    endtask

    task automatic refill_keys();
        foreach (key_pool[k]) key_pool[k] = $urandom;
    endtask

    task automatic send_random(int count);
        in_item_t it;
        int sel;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)      it.opcode = OP_UPSERT;
            else if (sel < 75) it.opcode = OP_RESOLVE;
            else if (sel < 95) it.opcode = OP_PURGE;
            else               it.opcode = OP_UNUSED;
            if ($urandom_range(0, 9) < 7) it.node_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else                          it.node_key = $urandom;
            it.address_in = ADDR_W'({$urandom, $urandom});
            // mostly advance the clock, now and then step it back
            if ($urandom_range(0, 19) == 0) cur_time = cur_time - $urandom_range(1, 200);
            else                            cur_time = cur_time + $urandom_range(0, 40);
            it.now_time = cur_time;
            if ($urandom_range(0, 49) == 0) it.now_time = TIME_W'({$urandom, $urandom});
            send_item(it, 1'b0, '0);
            if (!no_gaps && $urandom_range(0, 2) == 0) idle(gap_len());
        end
    endtask

    initial begin : stimulus
        row_t plan [$];
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        row_typed = 1'b0;
        row_want  = '0;
        hold_req  = 1'b0;
        no_gaps   = 1'b0;
        cur_time  = '0;
        age_limit = '0;
        mismatches = 0;
        quiet_cycles = 0;
        foreach (peer_live[i]) begin
            peer_live[i] = 1'b0;
            peer_key[i]  = '0;
            peer_addr[i] = '0;
            peer_seen[i] = '0;
        end

        plan.push_back('{mk_item(OP_RESOLVE, '0, '0, '0), 1'b1, mk_result(0, '0, 0, 0)});
        plan.push_back('{mk_item(OP_PURGE, '0, '0, TIME_MAX), 1'b1, mk_result(0, '0, 0, 0)});
        plan.push_back('{mk_item(OP_UPSERT, '0, '0, '0), 1'b1, mk_result(0, '0, 0, 0)});
        plan.push_back('{mk_item(OP_UPSERT, KEY_MAX, ADDR_MAX, TIME_MAX), 1'b1,
                         mk_result(0, '0, 1, 0)});
        plan.push_back('{mk_item(OP_RESOLVE, KEY_MAX, '0, '0), 1'b1,
                         mk_result(1, ADDR_MAX, 1, 0)});
        plan.push_back('{mk_item(OP_UNUSED, KEY_MAX, ADDR_MAX, TIME_MAX), 1'b1,
                         mk_result(0, '0, 0, 0)});
        plan.push_back('{mk_item(OP_UPSERT, '0, 48'h0123_4567_89ab, 63'd5), 1'b1,
                         mk_result(1, '0, 0, 0)});
        // clock behind every entry: nothing ages out
        plan.push_back('{mk_item(OP_PURGE, '0, '0, 63'd3), 1'b1, mk_result(0, '0, 0, 0)});
        plan.push_back('{mk_item(OP_PURGE, '0, '0, 63'd5), 1'b0, '0});
        plan.push_back('{mk_item(OP_PURGE, '0, '0, 63'd6), 1'b0, '0});
        plan.push_back('{mk_item(OP_RESOLVE, '0, '0, '0), 1'b1, mk_result(0, '0, 0, 0)});
        // fill the table, then evict the oldest and then break a tie
        for (int i = 0; i < PEER_SLOTS - 1; i++)
            plan.push_back('{mk_item(OP_UPSERT, 32'h8000_0000 | (32'h0101_0011 * i),
                                     48'hfedc_ba98_7654 ^ ADDR_W'(i), 63'd100), 1'b0, '0});
        plan.push_back('{mk_item(OP_UPSERT, KEY_MAX, '0, 63'd50), 1'b0, '0});
        plan.push_back('{mk_item(OP_UPSERT, 32'h5a5a_0001, ADDR_MAX, 63'd100), 1'b0, '0});
        plan.push_back('{mk_item(OP_UPSERT, 32'ha5a5_0002, 48'h1, 63'd100), 1'b0, '0});
        plan.push_back('{mk_item(OP_PURGE, '0, '0, TIME_MAX), 1'b0, '0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[n]) begin
            send_item(plan[n].item, plan[n].typed, plan[n].want);
            if ($urandom_range(0, 2) == 0) idle(gap_len());
        end
        wait_drain();

        // no entry can ever age out
        write_max_age(TIME_MAX);
        refill_keys();
        cur_time = '0;
        no_gaps = 1'b1;
        send_random(60);
        no_gaps = 1'b0;
        send_random(50);
        wait_drain();

        // every entry older than the current tick ages out; stall the results first
        write_max_age('0);
        refill_keys();
        hold_req = 1'b1;
        no_gaps = 1'b1;
        send_random(40);
        no_gaps = 1'b0;
        send_random(70);
        wait_drain();

        write_max_age(TIME_W'($urandom_range(20, 300)));
        refill_keys();
        send_random(55);
        wait_drain();
        send_random(55);
        wait_drain();

        write_max_age(TIME_W'({$urandom, $urandom}));
        refill_keys();
        cur_time = TIME_W'({$urandom, $urandom});
        send_random(110);
        wait_drain();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/ptlu_pkg.sv
src/ptlu_store.sv
src/peer_table_lru_upsert.sv
src/ptlu_checker.sv
test/peer_table_lru_upsert_tb.sv
